[rtl/msfd_pkg.sv]
// shared types and constants of the motor status frame decoder
`default_nettype none
package msfd_pkg;

	// status codes carried in frame id bits 15:8
	localparam logic [7:0] CODE_STATUS1 = 8'd9;
	localparam logic [7:0] CODE_STATUS2 = 8'd14;
	localparam logic [7:0] CODE_STATUS3 = 8'd15;
	localparam logic [7:0] CODE_STATUS4 = 8'd16;
	localparam logic [7:0] CODE_STATUS5 = 8'd27;

	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_STATUS1 = 3'd1;
	localparam logic [2:0] KIND_STATUS2 = 3'd2;
	localparam logic [2:0] KIND_STATUS3 = 3'd3;
	localparam logic [2:0] KIND_STATUS4 = 3'd4;
	localparam logic [2:0] KIND_STATUS5 = 3'd5;

	localparam logic [2:0] REG_CONTROLLER_ID  = 3'd0;
	localparam logic [2:0] REG_REVERSE        = 3'd1;
	localparam logic [2:0] REG_ZERO_EN        = 3'd2;
	localparam logic [2:0] REG_ANGLE_SCALE    = 3'd3;
	localparam logic [2:0] REG_VELOCITY_SCALE = 3'd4;

	localparam logic signed [15:0] POS_LOW    = 16'sd4500;
	localparam logic signed [15:0] POS_HIGH   = 16'sd13500;
	localparam logic signed [16:0] TURN_UNITS = 17'sd18000;

	localparam logic [5:0]  ZERO_FRAME = 6'd50;
	localparam logic [5:0]  FRAMES_MAX = 6'd63;
	localparam logic [31:0] ONE_Q824   = 32'h0100_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_DSUM,
		ST_DABS,
		ST_MUL,
		ST_NEG,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PATH_NONE,
		PATH_VEL,
		PATH_ANG
	} path_t;

	// control word from the sequencer to the shared arithmetic unit
	typedef struct packed {
		logic       ang;
		logic       ld_vel;
		logic       op_turn;
		logic       op_sum;
		logic       op_abs;
		logic       acc_clr;
		logic       mul_en;
		logic       acc_en;
		logic [1:0] pp_idx;
		logic [1:0] acc_idx;
		logic       store;
		logic       fin;
	} unit_ctrl_t;

endpackage
`default_nettype wire

[rtl/msfd_arith.sv]
// shared multiplier and accumulator for velocity and angle scaling
`default_nettype none
module msfd_arith (
	input  wire logic                clk,
	input  wire msfd_pkg::unit_ctrl_t ctrl,
	input  wire logic [31:0]         erpm,
	input  wire logic [31:0]         turns,
	input  wire logic signed [16:0]  pos_diff,
	input  wire logic [31:0]         scale,
	input  wire logic                reverse,
	output logic [63:0]              scaled
);
	import msfd_pkg::*;

	logic [47:0]        delta_q;
	logic [47:0]        mag_q;
	logic [47:0]        prod_q;
	logic               neg_q;
	logic [79:0]        acc_q;
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;
	logic [79:0]        addend;
	logic [47:0]        delta_neg;

	// signed turns times turn units, or one 32x16 partial product of mag times scale
	always_comb begin
		if (ctrl.op_turn) begin
			mul_a = {turns[31], turns};
			mul_b = TURN_UNITS;
		end else begin
			mul_a = {1'b0, (ctrl.pp_idx[1] ? {16'b0, mag_q[47:32]} : mag_q[31:0])};
			mul_b = {1'b0, (ctrl.pp_idx[0] ? scale[31:16] : scale[15:0])};
		end
		mul_p = mul_a * mul_b;
	end

	assign addend    = 80'(prod_q) << {ctrl.acc_idx, 4'b0000};
	assign delta_neg = 48'd0 - delta_q;

	always_ff @(posedge clk) begin
		if (ctrl.ld_vel) begin
			delta_q <= {{16{erpm[31]}}, erpm};
		end else if (ctrl.op_sum) begin
			delta_q <= prod_q + 48'(pos_diff);
		end
		if (ctrl.op_turn || ctrl.mul_en) begin
			prod_q <= mul_p[47:0];
		end
		if (ctrl.op_abs) begin
			mag_q <= delta_q[47] ? delta_neg : delta_q;
			neg_q <= delta_q[47] ^ reverse;
		end
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + addend;
		end
	end

	// drop 16 fraction bits of the q8.24 product, then apply the sign
	assign scaled = neg_q ? (64'd0 - acc_q[79:16]) : acc_q[79:16];

endmodule
`default_nettype wire

[rtl/msfd_seq.sv]
// sequencer that steps the shared arithmetic unit through one frame
`default_nettype none
module msfd_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire msfd_pkg::path_t  path,
	input  wire logic             out_free,
	output logic                  in_ready,
	output msfd_pkg::unit_ctrl_t  ctrl
);
	import msfd_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic       ang_q, ang_d;
	logic [2:0] pp_count;

	assign pp_count = ang_q ? 3'd4 : 3'd2;
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ang_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ang_q   <= ang_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ang_d    = ang_q;
		ctrl     = '0;
		ctrl.ang = ang_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (path)
						PATH_VEL: begin
							ctrl.ld_vel = 1'b1;
							ang_d       = 1'b0;
							state_d     = ST_DABS;
						end
						PATH_ANG: begin
							ang_d   = 1'b1;
							state_d = ST_DELTA;
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_DELTA: begin
				ctrl.op_turn = 1'b1;
				state_d      = ST_DSUM;
			end
			ST_DSUM: begin
				ctrl.op_sum = 1'b1;
				state_d     = ST_DABS;
			end
			ST_DABS: begin
				ctrl.op_abs  = 1'b1;
				ctrl.acc_clr = 1'b1;
				cnt_d        = '0;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				// product of step n is registered, then added at step n+1
				if (cnt_q != pp_count) begin
					ctrl.mul_en = 1'b1;
					ctrl.pp_idx = cnt_q[1:0];
				end
				if (cnt_q != 3'd0) begin
					ctrl.acc_en  = 1'b1;
					ctrl.acc_idx = 2'(cnt_q - 3'd1);
				end
				if (cnt_q == pp_count) begin
					state_d = ST_NEG;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			ST_NEG: begin
				ctrl.store = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					ctrl.fin = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/motor_status_frame_decoder_top.sv]
// Motor status frame decoder: takes one received extended-ID CAN frame per beat on the
// input channel (valid/ready) and, for a frame whose id low byte matches controller_id,
// gives one decoded beat on the output channel (valid/ready). Foreign or standard
// frames are taken and dropped with no result.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it only
// while the block is idle. Indexes 0..4: controller_id, reverse, zeroing enable,
// angle_scale, velocity_scale; other indexes are ignored.
// One frame is handled at a time; in_ready returns in the same cycle as out_valid,
// when the result is loaded into the output register. The single shared 33x17
// multiplier forms turns*18000 for angle frames, then two (velocity) or four (angle)
// partial products of the magnitude times the q8.24 scale, one per cycle.
// A stalled receiver holds the output register; a finished frame then waits in the
// final step and no new frame is taken until the output register is free.
// Reset (arst_n low) clears the configuration to its defaults, the turn counter,
// positions, frame counter, held velocity and angle, and empties the output.
`default_nettype none
module motor_status_frame_decoder_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               is_extended,
	input  wire logic [28:0]        frame_id,
	input  wire logic [63:0]        payload,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              kind,
	output logic signed [31:0]      first_value,
	output logic signed [31:0]      second_value,
	output logic signed [15:0]      third_value,
	output logic signed [15:0]      fourth_value,
	output logic signed [47:0]      velocity,
	output logic signed [63:0]      abs_angle,
	output logic signed [31:0]      turn_count,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import msfd_pkg::*;

	// configuration
	logic [7:0]  controller_id_q;
	logic        reverse_q;
	logic        zero_en_q;
	logic [31:0] angle_scale_q;
	logic [31:0] velocity_scale_q;

	// decoder state
	logic [15:0] last_pos_q;
	logic [31:0] turns_q;
	logic [15:0] zero_pos_q;
	logic [5:0]  frames_q;
	logic [47:0] velocity_q;
	logic [63:0] angle_q;

	// fields of the frame in flight
	logic [2:0]  w_kind_q;
	logic [31:0] w_first_q;
	logic [31:0] w_second_q;
	logic [15:0] w_third_q;
	logic [15:0] w_fourth_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [31:0] first_q;
	logic [31:0] second_q;
	logic [15:0] third_q;
	logic [15:0] fourth_q;
	logic [47:0] velocity_out_q;
	logic [63:0] angle_out_q;
	logic [31:0] turns_out_q;

	logic              in_acc;
	logic              start;
	logic [15:0]       h0, h1, h2, h3;
	logic [31:0]       hi32, lo32;
	logic [2:0]        dec_kind;
	logic [31:0]       dec_first, dec_second;
	logic [15:0]       dec_third, dec_fourth;
	path_t             dec_path;
	logic [5:0]        frames_next;
	logic              az;
	logic              turn_up, turn_dn;
	logic signed [16:0] pos_diff;
	logic [31:0]       scale;
	logic [63:0]       scaled;
	logic              out_free;
	unit_ctrl_t        ctrl;

	assign in_acc = in_valid && in_ready;
	assign start  = in_acc && is_extended && (frame_id[7:0] == controller_id_q);

	assign hi32 = payload[63:32];
	assign lo32 = payload[31:0];
	assign h0   = payload[63:48];
	assign h1   = payload[47:32];
	assign h2   = payload[31:16];
	assign h3   = payload[15:0];

	always_comb begin
		dec_kind   = KIND_NONE;
		dec_first  = '0;
		dec_second = '0;
		dec_third  = '0;
		dec_fourth = '0;
		dec_path   = PATH_NONE;
		unique case (frame_id[15:8])
			CODE_STATUS1: begin
				dec_kind   = KIND_STATUS1;
				dec_first  = hi32;
				dec_second = {{16{h2[15]}}, h2};
				dec_third  = h3;
				dec_path   = PATH_VEL;
			end
			CODE_STATUS2: begin
				dec_kind   = KIND_STATUS2;
				dec_first  = hi32;
				dec_second = lo32;
			end
			CODE_STATUS3: begin
				dec_kind   = KIND_STATUS3;
				dec_first  = hi32;
				dec_second = lo32;
			end
			CODE_STATUS4: begin
				dec_kind   = KIND_STATUS4;
				dec_first  = {{16{h0[15]}}, h0};
				dec_second = {{16{h1[15]}}, h1};
				dec_third  = h2;
				dec_fourth = h3;
				dec_path   = PATH_ANG;
			end
			CODE_STATUS5: begin
				dec_kind   = KIND_STATUS5;
				dec_first  = hi32;
				dec_second = {{16{h2[15]}}, h2};
			end
			default: begin
				dec_kind = KIND_NONE;
			end
		endcase
	end

	assign frames_next = (frames_q == FRAMES_MAX) ? FRAMES_MAX : frames_q + 6'd1;
	assign az = (dec_kind != KIND_NONE) && (frames_next == ZERO_FRAME) && zero_en_q;

	// crossing between the 90 and 270 degree regions
	assign turn_up = (signed'(h3) < POS_LOW) && (signed'(last_pos_q) > POS_HIGH);
	assign turn_dn = (signed'(h3) > POS_HIGH) && (signed'(last_pos_q) < POS_LOW);

	assign pos_diff = 17'(signed'(last_pos_q)) - 17'(signed'(zero_pos_q));
	assign scale    = ctrl.ang ? angle_scale_q : velocity_scale_q;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			controller_id_q  <= '0;
			reverse_q        <= 1'b0;
			zero_en_q        <= 1'b0;
			angle_scale_q    <= ONE_Q824;
			velocity_scale_q <= ONE_Q824;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONTROLLER_ID:  controller_id_q  <= cfg_data[7:0];
				REG_REVERSE:        reverse_q        <= cfg_data[0];
				REG_ZERO_EN:        zero_en_q        <= cfg_data[0];
				REG_ANGLE_SCALE:    angle_scale_q    <= cfg_data;
				REG_VELOCITY_SCALE: velocity_scale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
			turns_q    <= '0;
			zero_pos_q <= '0;
			frames_q   <= '0;
			velocity_q <= '0;
			angle_q    <= '0;
		end else begin
			if (start) begin
				frames_q <= frames_next;
				if (dec_kind == KIND_STATUS4) begin
					last_pos_q <= h3;
				end
				// zeroing: a kind 4 frame then recomputes an angle of zero
				if (az) begin
					turns_q    <= '0;
					zero_pos_q <= (dec_kind == KIND_STATUS4) ? h3 : last_pos_q;
					angle_q    <= '0;
				end else if ((dec_kind == KIND_STATUS4) && turn_up) begin
					turns_q <= turns_q + 32'd1;
				end else if ((dec_kind == KIND_STATUS4) && turn_dn) begin
					turns_q <= turns_q - 32'd1;
				end
			end
			if (ctrl.store) begin
				if (ctrl.ang) begin
					angle_q <= scaled;
				end else begin
					velocity_q <= scaled[47:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_kind_q   <= dec_kind;
			w_first_q  <= dec_first;
			w_second_q <= dec_second;
			w_third_q  <= dec_third;
			w_fourth_q <= dec_fourth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			kind_q         <= w_kind_q;
			first_q        <= w_first_q;
			second_q       <= w_second_q;
			third_q        <= w_third_q;
			fourth_q       <= w_fourth_q;
			velocity_out_q <= velocity_q;
			angle_out_q    <= angle_q;
			turns_out_q    <= turns_q;
		end
	end

	msfd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.path     (dec_path),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	msfd_arith u_arith (
		.clk      (clk),
		.ctrl     (ctrl),
		.erpm     (hi32),
		.turns    (turns_q),
		.pos_diff (pos_diff),
		.scale    (scale),
		.reverse  (reverse_q),
		.scaled   (scaled)
	);

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign first_value  = first_q;
	assign second_value = second_q;
	assign third_value  = third_q;
	assign fourth_value = fourth_q;
	assign velocity     = velocity_out_q;
	assign abs_angle    = angle_out_q;
	assign turn_count   = turns_out_q;

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("decoder still ready after taking a matching frame");

	a_frames_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(frames_q == FRAMES_MAX) |=> (frames_q == FRAMES_MAX))
		else $error("frame counter left saturation");

	a_zero_turns: assert property (@(posedge clk) disable iff (!arst_n)
		(start && az) |=> (turns_q == 32'd0))
		else $error("zeroing did not clear the turn counter");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fin |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken output beat");
`endif

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the motor status frame decoder, with a local status predictor
`timescale 1ns / 1ps
module testbench;
	import msfd_pkg::*;

	typedef struct {
		logic        ext;
		logic [28:0] id;
		logic [63:0] data;
		bit          calm;
	} can_frame_t;

	typedef struct {
		logic [2:0]         kind;
		logic signed [31:0] first_value;
		logic signed [31:0] second_value;
		logic signed [15:0] third_value;
		logic signed [15:0] fourth_value;
		logic signed [47:0] velocity;
		logic signed [63:0] abs_angle;
		logic signed [31:0] turn_count;
	} status_beat_t;

	// position walk through every unwrap case
	localparam logic [15:0] WALK_POS [9] = '{16'd13600, 16'd100, 16'd13501, 16'hFFFF,
		16'd13500, 16'd4500, 16'h8000, 16'h7FFF, 16'd4499};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic is_extended = 1'b0;
	logic [28:0] frame_id = '0;
	logic [63:0] payload = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] kind;
	logic signed [31:0] first_value;
	logic signed [31:0] second_value;
	logic signed [15:0] third_value;
	logic signed [15:0] fourth_value;
	logic signed [47:0] velocity;
	logic signed [63:0] abs_angle;
	logic signed [31:0] turn_count;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// predictor copy of the registers
	logic [7:0]  c_ctrl_id = '0;
	logic        c_reverse = 1'b0;
	logic        c_zero_en = 1'b0;
	logic [31:0] c_ang_scale = ONE_Q824;
	logic [31:0] c_vel_scale = ONE_Q824;

	// predictor copy of the decoder state
	logic [15:0] m_last_pos = '0;
	logic [31:0] m_turns = '0;
	logic [15:0] m_zero_pos = '0;
	logic [5:0]  m_frames = '0;
	logic [47:0] m_vel = '0;
	logic [63:0] m_ang = '0;

	can_frame_t   frame_q[$];
	status_beat_t expected_status[$];
	int  hits_queued = 0;
	int  fault_cnt = 0;
	int  tx_gap = 0;
	int  rx_stall = 0;
	logic cur_calm = 1'b0;
	bit  hold_go = 1'b0;
	logic rx_hold = 1'b0;

	motor_status_frame_decoder_top i_dut (
		.clk, .arst_n, .in_valid, .in_ready, .is_extended, .frame_id, .payload,
		.out_valid, .out_ready, .kind, .first_value, .second_value, .third_value,
		.fourth_value, .velocity, .abs_angle, .turn_count, .cfg_we, .cfg_index, .cfg_data
	);

	always #1 clk = ~clk;

	// trunc(|d| * s / 2^16), sign from d and flip
	function automatic logic [63:0] q824_scale(input longint d, input logic [31:0] s,
			input bit flip);
		logic [63:0] mag;
		logic [95:0] prod;
		logic [63:0] r;
		bit neg;
		neg = flip ^ (d < 0);
		mag = (d < 0) ? 64'(-d) : 64'(d);
		prod = {32'b0, mag} * {64'b0, s};
		r = prod[79:16];
		return neg ? -r : r;
	endfunction

	task automatic decode_frame(input logic ext, input logic [28:0] id, input logic [63:0] pl);
		status_beat_t s;
		logic signed [15:0] np;
		logic signed [15:0] op;
		logic [63:0] wide;
		longint delta;
		if (!ext || id[7:0] != c_ctrl_id)
			return;
		s = '{default: '0};
		if (m_frames != FRAMES_MAX)
			m_frames++;
		case (id[15:8])
			CODE_STATUS1: begin
				s.kind = KIND_STATUS1;
				s.first_value = pl[63:32];
				s.second_value = {{16{pl[31]}}, pl[31:16]};
				s.third_value = pl[15:0];
				wide = q824_scale(longint'($signed(pl[63:32])), c_vel_scale, c_reverse);
				m_vel = wide[47:0];
			end
			CODE_STATUS2, CODE_STATUS3: begin
				s.kind = (id[15:8] == CODE_STATUS2) ? KIND_STATUS2 : KIND_STATUS3;
				s.first_value = pl[63:32];
				s.second_value = pl[31:0];
			end
			CODE_STATUS4: begin
				s.kind = KIND_STATUS4;
				s.first_value = {{16{pl[63]}}, pl[63:48]};
				s.second_value = {{16{pl[47]}}, pl[47:32]};
				s.third_value = pl[31:16];
				s.fourth_value = pl[15:0];
				np = pl[15:0];
				op = m_last_pos;
				if (np < POS_LOW && op > POS_HIGH)
					m_turns++;
				else if (np > POS_HIGH && op < POS_LOW)
					m_turns--;
				m_last_pos = pl[15:0];
				delta = longint'($signed(m_turns)) * longint'(TURN_UNITS)
					+ longint'($signed(m_last_pos)) - longint'($signed(m_zero_pos));
				m_ang = q824_scale(delta, c_ang_scale, c_reverse);
			end
			CODE_STATUS5: begin
				s.kind = KIND_STATUS5;
				s.first_value = pl[63:32];
				s.second_value = {{16{pl[31]}}, pl[31:16]};
			end
			default: ;
		endcase
		// zeroing on the fiftieth decoded frame, known kinds only
		if (s.kind != KIND_NONE && m_frames == ZERO_FRAME && c_zero_en) begin
			m_turns = '0;
			m_zero_pos = m_last_pos;
			m_ang = '0;
		end
		s.velocity = m_vel;
		s.abs_angle = m_ang;
		s.turn_count = m_turns;
		expected_status.push_back(s);
	endtask

	function automatic void check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			fault_cnt++;
			if (fault_cnt <= 10)
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endfunction

	task automatic queue_frame(input logic ext, input logic [28:0] id, input logic [63:0] data,
			input bit calm);
		if (ext && id[7:0] == c_ctrl_id)
			hits_queued++;
		frame_q.push_back(can_frame_t'{ext, id, data, calm});
	endtask

	function automatic can_frame_t random_frame();
		can_frame_t f;
		int pick;
		logic [7:0] code;
		logic [7:0] who;
		logic [15:0] pos;
		pick = $urandom_range(0, 99);
		f.ext = 1'b1;
		who = c_ctrl_id;
		if (pick < 5)
			f.ext = 1'b0;
		else if (pick < 13) begin
			who = 8'($urandom);
			if (who == c_ctrl_id)
				who = ~who;
		end
		case ($urandom_range(0, 11))
			0, 1: code = CODE_STATUS1;
			2: code = CODE_STATUS2;
			3: code = CODE_STATUS3;
			4, 5, 6, 7, 8: code = CODE_STATUS4;
			9: code = CODE_STATUS5;
			default: code = 8'($urandom);
		endcase
		// make sure the fiftieth decoded frame is a known kind
		if (f.ext && who == c_ctrl_id && hits_queued == ZERO_FRAME - 1)
			code = CODE_STATUS4;
		f.id = {13'($urandom), code, who};
		f.data = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0: f.data[63:32] = 32'h8000_0000;
				1: f.data[63:32] = 32'h7FFF_FFFF;
				2: f.data[63:32] = 32'h0;
				default: f.data[63:32] = 32'hFFFF_FFFF;
			endcase
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3: pos = 16'($urandom_range(0, POS_LOW - 1));
			4, 5, 6, 7: pos = 16'($urandom_range(POS_HIGH + 1, TURN_UNITS - 1));
			8: pos = 16'($urandom);
			default: begin
				case ($urandom_range(0, 9))
					0: pos = POS_LOW - 16'sd1;
					1: pos = POS_LOW;
					2: pos = POS_LOW + 16'sd1;
					3: pos = POS_HIGH - 16'sd1;
					4: pos = POS_HIGH;
					5: pos = POS_HIGH + 16'sd1;
					6: pos = 16'h8000;
					7: pos = 16'h7FFF;
					8: pos = 16'hFFFF;
					default: pos = 16'h0;
				endcase
			end
		endcase
		if (code == CODE_STATUS4)
			f.data[15:0] = pos;
		return f;
	endfunction

	task automatic queue_random_frames(input int count, input int calm_tail);
		can_frame_t f;
		bit chunk_calm;
		chunk_calm = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				chunk_calm = ($urandom_range(0, 3) == 0);
			f = random_frame();
			queue_frame(f.ext, f.id, f.data, chunk_calm || i >= count - calm_tail);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_CONTROLLER_ID: c_ctrl_id = data[7:0];
			REG_REVERSE: c_reverse = data[0];
			REG_ZERO_EN: c_zero_en = data[0];
			REG_ANGLE_SCALE: c_ang_scale = data;
			REG_VELOCITY_SCALE: c_vel_scale = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// dropped frames leave no result, so wait for the longest frame handling after the queues empty
	task automatic wait_drained();
		do
			@(negedge clk);
		while (frame_q.size() != 0 || in_valid || expected_status.size() != 0);
		repeat (24) @(negedge clk);
	endtask

	// sender
	always @(posedge clk) begin : drive_frames
		can_frame_t f;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				decode_frame(is_extended, frame_id, payload);
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (frame_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!frame_q[0].calm && $urandom_range(0, 5) == 0) begin
					tx_gap = $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else begin
					f = frame_q.pop_front();
					in_valid <= 1'b1;
					is_extended <= f.ext;
					frame_id <= f.id;
					payload <= f.data;
					cur_calm <= f.calm;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n || rx_hold) begin
			out_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else if (!cur_calm && $urandom_range(0, 5) == 0) begin
			rx_stall = $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// long receiver hold so the decoder backs up into its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin : check_results
		status_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_status.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= 10)
					$display("%0t: result beat with none expected, kind %0d", $time, kind);
			end else begin
				want = expected_status.pop_front();
				check_field("kind", kind, want.kind);
				check_field("first_value", first_value, want.first_value);
				check_field("second_value", second_value, want.second_value);
				check_field("third_value", third_value, want.third_value);
				check_field("fourth_value", fourth_value, want.fourth_value);
				check_field("velocity", velocity, want.velocity);
				check_field("abs_angle", abs_angle, want.abs_angle);
				check_field("turn_count", turn_count, want.turn_count);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin : run_phases
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		// reset settings: drops, unknown codes, field extremes, unwrap walk
		queue_frame(1'b0, {13'h0, CODE_STATUS1, c_ctrl_id}, '1, 1'b0);
		queue_frame(1'b1, {13'h0, CODE_STATUS1, c_ctrl_id ^ 8'h01}, '1, 1'b0);
		queue_frame(1'b1, '1, '1, 1'b0);
		queue_frame(1'b1, '0, '1, 1'b0);
		queue_frame(1'b1, {13'h1FFF, 8'hFF, c_ctrl_id}, '1, 1'b0);
		queue_frame(1'b1, {13'h1FFF, CODE_STATUS1, c_ctrl_id}, 64'h7FFF_FFFF_8000_7FFF, 1'b0);
		queue_frame(1'b1, {13'h0, CODE_STATUS1, c_ctrl_id}, 64'h8000_0000_FFFF_FFFF, 1'b0);
		queue_frame(1'b1, {13'h0, CODE_STATUS1, c_ctrl_id}, '0, 1'b0);
		queue_frame(1'b1, {13'h0, CODE_STATUS2, c_ctrl_id}, '1, 1'b0);
		queue_frame(1'b1, {13'h0, CODE_STATUS3, c_ctrl_id}, 64'h8000_0000_7FFF_FFFF, 1'b0);
		queue_frame(1'b1, {13'h0, CODE_STATUS5, c_ctrl_id}, {$urandom, $urandom}, 1'b0);
		for (int i = 0; i < 9; i++)
			queue_frame(1'b1, {13'h0, CODE_STATUS4, c_ctrl_id},
				{(i % 2 == 1) ? 48'hFFFF_8000_7FFF : 48'h7FFF_0000_8000, WALK_POS[i]}, 1'b0);
		wait_drained();

		write_reg(REG_CONTROLLER_ID, {24'($urandom), 8'h5A});
		write_reg(REG_REVERSE, {31'($urandom), 1'b0});
		write_reg(REG_ZERO_EN, {31'($urandom), 1'b1});
		write_reg(REG_ANGLE_SCALE, $urandom);
		write_reg(REG_VELOCITY_SCALE, $urandom);
		for (int r = REG_VELOCITY_SCALE + 1; r < (1 << $bits(cfg_index)); r++)
			write_reg(3'(r), $urandom);
		@(negedge clk);
		queue_random_frames(300, 0);
		hold_go = 1'b1;
		wait_drained();

		write_reg(REG_CONTROLLER_ID, 32'hFF);
		write_reg(REG_REVERSE, 32'h1);
		write_reg(REG_ZERO_EN, 32'h0);
		write_reg(REG_ANGLE_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_VELOCITY_SCALE, 32'hFFFF_FFFF);
		@(negedge clk);
		queue_random_frames(300, 0);
		wait_drained();

		write_reg(REG_CONTROLLER_ID, 32'h0);
		write_reg(REG_REVERSE, 32'h0);
		write_reg(REG_ANGLE_SCALE, 32'h0);
		write_reg(REG_VELOCITY_SCALE, 32'h0);
		@(negedge clk);
		queue_random_frames(200, 0);
		wait_drained();

		write_reg(REG_CONTROLLER_ID, $urandom);
		write_reg(REG_REVERSE, $urandom);
		write_reg(REG_ZERO_EN, $urandom);
		write_reg(REG_ANGLE_SCALE, $urandom);
		write_reg(REG_VELOCITY_SCALE, $urandom);
		@(negedge clk);
		// no idling on either side over the tail
		queue_random_frames(500, 200);
		wait_drained();

		fault_cnt += expected_status.size();
		if (fault_cnt == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
